// File: src/crf_pkg.sv
// ----------------------------------------------------------------------------
// crf_pkg
// Types and fixed tables of the comb filter reverb: delay lengths, comb
// gains, output gain and configuration register indexes.
// ----------------------------------------------------------------------------
package crf_pkg;

  // Number of parallel combs and per-comb position width
  localparam int COMB_COUNT = 4;
  localparam int COMB_W     = 2;
  localparam int POS_W      = 14;
  localparam int WORD_W     = 32;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SET  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_ROW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EXTRA_TAPS = 2'd2;

  localparam logic [2:0] EXTRA_TAPS_RESET = 3'd4;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [15:0]       gain_t;

  // Delay lengths: [set][row][comb]
  localparam pos_t DELAY_TABLE [0:1][0:3][0:COMB_COUNT-1] = '{
    '{ '{14'd2063, 14'd1847, 14'd1523, 14'd1277},
       '{14'd3089, 14'd2927, 14'd2801, 14'd2111},
       '{14'd5479, 14'd5077, 14'd4987, 14'd4057},
       '{14'd9929, 14'd7411, 14'd4951, 14'd1063} },
    '{ '{14'd2053, 14'd1867, 14'd1531, 14'd1259},
       '{14'd3109, 14'd2939, 14'd2803, 14'd2113},
       '{14'd5477, 14'd5059, 14'd4993, 14'd4051},
       '{14'd9949, 14'd7393, 14'd4957, 14'd1097} }
  };

  // Feedback gains, unsigned Q0.16, applied negated
  localparam gain_t COMB_GAIN [0:COMB_COUNT-1] = '{
    16'd57233, 16'd53890, 16'd55791, 16'd55725
  };

  // 0.3 in Q0.16
  localparam logic signed [15:0] OUT_GAIN = 16'sd19661;

endpackage

// File: src/comb_filter_reverb.sv
// ----------------------------------------------------------------------------
// comb_filter_reverb
// Four feedback comb filters share one delay-line RAM (COMB_COUNT*LINE_DEPTH
// 32-bit words, one read and one write port, registered read). Each request
// runs the combs one after the other: reduce the position modulo the delay
// length (one compare-subtract per cycle), read extra_taps+1 taps, average
// them in a radix-256 divider, add the input, scale by the negative gain
// and write back. A new request is taken while the previous result still
// waits in the output register. After reset the RAM is cleared one word a
// cycle, all COMB_COUNT*LINE_DEPTH words (65536 at default), with in_stall
// high; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module comb_filter_reverb #(
  parameter int LINE_DEPTH  = 16384,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // configuration
  input  logic                                  cfg_we,
  input  logic [crf_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [crf_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input requests
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0]         in_sample_in,
  // results
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [SAMPLE_BITS-1:0]         out_sample_out
);

  localparam int MEM_DEPTH = crf_pkg::COMB_COUNT * LINE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic signed [35:0] OUT_MAX =
    36'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [35:0] OUT_MIN = -OUT_MAX - 36'sd1;

  localparam logic signed [34:0] W_MAX = 35'sd2147483647;
  localparam logic signed [34:0] W_MIN = -35'sd2147483648;

  localparam logic [2:0] DIV_STEPS = 3'd5;

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_REDUCE = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_SUM    = 4'd6;
  localparam logic [3:0] S_MUL    = 4'd7;
  localparam logic [3:0] S_WRITE  = 4'd8;
  localparam logic [3:0] S_OMUL   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  // registers
  logic [3:0]                    state_r, state_nxt;
  logic                          set_r, set_nxt;
  logic [1:0]                    row_r, row_nxt;
  logic [2:0]                    xtaps_r, xtaps_nxt;
  logic signed [SAMPLE_BITS-1:0] a_r, a_nxt;
  logic [crf_pkg::COMB_W-1:0]    comb_r, comb_nxt;
  crf_pkg::pos_t                 pos_r, pos_nxt;
  crf_pkg::pos_t                 tap_r, tap_nxt;
  logic [3:0]                    iss_r, iss_nxt;
  logic                          pend_r, pend_nxt;
  logic signed [34:0]            sum_r, sum_nxt;
  logic [39:0]                   div_num_r, div_num_nxt;
  logic [4:0]                    div_rem_r, div_rem_nxt;
  logic                          div_neg_r, div_neg_nxt;
  logic [2:0]                    div_cnt_r, div_cnt_nxt;
  logic signed [32:0]            c_r, c_nxt;
  logic signed [49:0]            prod_r, prod_nxt;
  logic signed [34:0]            total_r, total_nxt;
  logic signed [52:0]            oprod_r, oprod_nxt;
  logic signed [SAMPLE_BITS-1:0] out_r, out_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]             clr_r, clr_nxt;
  crf_pkg::pos_t                 position_r [crf_pkg::COMB_COUNT];
  crf_pkg::word_t                rdata_r;

  // delay-line RAM
  crf_pkg::word_t                line_mem [MEM_DEPTH];

  // RAM access
  logic                          rd_en, wr_en;
  logic [ADDR_W-1:0]             rd_addr, wr_addr, base_addr;
  crf_pkg::word_t                wr_data;

  // datapath helpers
  crf_pkg::pos_t                 len;
  crf_pkg::pos_t                 tap_step;
  crf_pkg::pos_t                 pos_inc;
  logic [3:0]                    taps;
  logic [4:0]                    dvs;
  logic [36:0]                   n_val;
  logic [39:0]                   step_num;
  logic [4:0]                    step_rem;
  logic [4:0]                    rem_sh;
  logic [39:0]                   q_full;
  logic signed [31:0]            avg;
  logic signed [50:0]            wsum;
  logic signed [34:0]            w35;
  crf_pkg::word_t                w_sat;
  logic signed [36:0]            osum;
  logic signed [52:0]            ysum;
  logic signed [35:0]            y36;
  logic signed [SAMPLE_BITS-1:0] y_sat;
  logic                          pos_load_en, pos_wr_en;

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_r;

  // comb geometry
  assign len       = crf_pkg::DELAY_TABLE[set_r][row_r][comb_r];
  assign taps      = {1'b0, xtaps_r} + 4'd1;
  assign dvs       = {taps, 1'b0};
  assign base_addr = ADDR_W'(comb_r) * ADDR_W'(LINE_DEPTH);
  assign tap_step  = (tap_r + 14'd2 >= len) ? tap_r + 14'd2 - len : tap_r + 14'd2;
  assign pos_inc   = (pos_r + 14'd1 == len) ? '0 : pos_r + 14'd1;

  // divider numerator 2*sum + taps, folded to a magnitude
  assign n_val = {sum_r[34], sum_r, 1'b0} + {33'd0, taps};

  // eight restoring steps per cycle on a narrow remainder
  always_comb begin
    step_num = div_num_r;
    step_rem = div_rem_r;
    rem_sh   = '0;
    for (int k = 0; k < 8; k++) begin
      rem_sh   = {step_rem[3:0], step_num[39]};
      step_num = {step_num[38:0], 1'b0};
      if (rem_sh >= dvs) begin
        step_rem    = rem_sh - dvs;
        step_num[0] = 1'b1;
      end else begin
        step_rem = rem_sh;
      end
    end
  end

  // floor of a negative quotient comes back through the complement
  assign q_full = div_neg_r ? ~div_num_r : div_num_r;
  assign avg    = $signed(q_full[31:0]);

  // feedback word: round(-(c*g) / 2^16), saturated to 32 bits
  assign wsum = 51'sd32768 - 51'(prod_r);
  assign w35  = $signed(wsum[50:16]);
  always_comb begin
    if (w35 > W_MAX) begin
      w_sat = 32'h7FFF_FFFF;
    end else if (w35 < W_MIN) begin
      w_sat = 32'h8000_0000;
    end else begin
      w_sat = w35[31:0];
    end
  end

  // output: round((a + 2*total) * 0.3 / 2), saturated
  assign osum = 37'(a_r) + (37'(total_r) <<< 1);
  assign ysum = oprod_r + 53'sd65536;
  assign y36  = $signed(ysum[52:17]);
  always_comb begin
    if (y36 > OUT_MAX) begin
      y_sat = SAMPLE_BITS'(OUT_MAX);
    end else if (y36 < OUT_MIN) begin
      y_sat = SAMPLE_BITS'(OUT_MIN);
    end else begin
      y_sat = SAMPLE_BITS'(y36);
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    set_nxt       = set_r;
    row_nxt       = row_r;
    xtaps_nxt     = xtaps_r;
    a_nxt         = a_r;
    comb_nxt      = comb_r;
    pos_nxt       = pos_r;
    tap_nxt       = tap_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    sum_nxt       = sum_r;
    div_num_nxt   = div_num_r;
    div_rem_nxt   = div_rem_r;
    div_neg_nxt   = div_neg_r;
    div_cnt_nxt   = div_cnt_r;
    c_nxt         = c_r;
    prod_nxt      = prod_r;
    total_nxt     = total_r;
    oprod_nxt     = oprod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    clr_nxt       = clr_r;
    rd_en         = 1'b0;
    rd_addr       = base_addr + ADDR_W'(tap_r);
    wr_en         = 1'b0;
    wr_addr       = base_addr + ADDR_W'(pos_r);
    wr_data       = w_sat;
    pos_load_en   = 1'b0;
    pos_wr_en     = 1'b0;

    // configuration writes
    if (cfg_we) begin
      case (cfg_index)
        crf_pkg::REG_DELAY_SET:  set_nxt   = cfg_data[0];
        crf_pkg::REG_DELAY_ROW:  row_nxt   = cfg_data[1:0];
        crf_pkg::REG_EXTRA_TAPS: xtaps_nxt = cfg_data[2:0];
        default: ;
      endcase
    end

    // pending read data lands in the cycle after issue
    if (pend_r) begin
      sum_nxt = sum_r + 35'($signed(rdata_r));
    end

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          a_nxt     = in_sample_in;
          comb_nxt  = '0;
          total_nxt = '0;
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        pos_load_en = 1'b1;
        state_nxt   = S_REDUCE;
      end
      S_REDUCE: begin
        if (pos_r >= len) begin
          pos_nxt = pos_r - len;
        end else begin
          tap_nxt   = pos_r;
          iss_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (iss_r != taps) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          tap_nxt  = tap_step;
          iss_nxt  = iss_r + 4'd1;
        end else if (!pend_r) begin
          div_neg_nxt = n_val[36];
          div_num_nxt = {3'b000, n_val[36] ? ~n_val : n_val};
          div_rem_nxt = '0;
          div_cnt_nxt = '0;
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        div_num_nxt = step_num;
        div_rem_nxt = step_rem;
        div_cnt_nxt = div_cnt_r + 3'd1;
        if (div_cnt_r == DIV_STEPS - 3'd1) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        c_nxt     = 33'(a_r) + 33'(avg);
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = c_r * $signed({1'b0, crf_pkg::COMB_GAIN[comb_r]});
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        wr_en     = 1'b1;
        pos_wr_en = 1'b1;
        total_nxt = total_r + 35'(c_r);
        if (comb_r == crf_pkg::COMB_W'(crf_pkg::COMB_COUNT - 1)) begin
          state_nxt = S_OMUL;
        end else begin
          comb_nxt  = comb_r + 1'b1;
          state_nxt = S_LOAD;
        end
      end
      S_OMUL: begin
        oprod_nxt = osum * crf_pkg::OUT_GAIN;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for a free output register
        if (!out_valid_r || !out_stall) begin
          out_nxt       = y_sat;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (pos_load_en) begin
      pos_nxt = position_r[comb_r];
    end
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      set_r       <= 1'b0;
      row_r       <= '0;
      xtaps_r     <= crf_pkg::EXTRA_TAPS_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      for (int i = 0; i < crf_pkg::COMB_COUNT; i++) begin
        position_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      set_r       <= set_nxt;
      row_r       <= row_nxt;
      xtaps_r     <= xtaps_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      clr_r       <= clr_nxt;
      if (pos_wr_en) begin
        position_r[comb_r] <= pos_inc;
      end
    end
    a_r       <= a_nxt;
    comb_r    <= comb_nxt;
    pos_r     <= pos_nxt;
    tap_r     <= tap_nxt;
    iss_r     <= iss_nxt;
    sum_r     <= sum_nxt;
    div_num_r <= div_num_nxt;
    div_rem_r <= div_rem_nxt;
    div_neg_r <= div_neg_nxt;
    div_cnt_r <= div_cnt_nxt;
    c_r       <= c_nxt;
    prod_r    <= prod_nxt;
    total_r   <= total_nxt;
    oprod_r   <= oprod_nxt;
    out_r     <= out_nxt;
  end

  // delay-line RAM ports; combs run one at a time, so a write never
  // overlaps a read of the same word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= line_mem[rd_addr];
    end
  end

endmodule
